// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl in this folder
// assumes a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

// ===== src/eca_pkg.sv =====
// shared types and constants of the affine point adder
// no dependencies
package eca_pkg;

  localparam int DATA_BITS = 64;

  // configuration register indexes
  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_CURVE_A = 1'b1;

  // status of the serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } sdu_stat_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED,
    ST_CMP,
    ST_DSQ,
    ST_D2,
    ST_D3,
    ST_DA,
    ST_INV,
    ST_LAM,
    ST_SQR,
    ST_X3A,
    ST_X3B,
    ST_XD,
    ST_YMUL,
    ST_Y3,
    ST_DONE
  } state_t;

endpackage

// ===== src/eca_serial_unit.sv =====
// bit-serial divide / modular multiply-accumulate unit
// one dividend bit per cycle: remainder of n/d and (n/d)*t mod m
// depends on eca_pkg and assert_macros.svh
`include "assert_macros.svh"

module eca_serial_unit #(
  parameter int W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [W-1:0]       n_in,
  input  logic [W-1:0]       d_in,
  input  logic [W-1:0]       t_in,
  input  logic [W-1:0]       m_in,
  output eca_pkg::sdu_stat_t stat,
  output logic [W-1:0]       rem,
  output logic [W-1:0]       prod
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  n_r, n_nxt, d_r, d_nxt, t_r, t_nxt, m_r, m_nxt;
  logic [W-1:0]  rem_r, rem_nxt, acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]    rem_sh, rem_sub;
  logic          ge;
  logic [W-1:0]  acc2, acc3;

  function automatic logic [W-1:0] madd(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W-1:0] gap;
    gap  = m - b;
    madd = (a >= gap) ? (a - gap) : (a + b);
  endfunction

  always_comb begin
    rem_sh  = {rem_r, n_r[W-1]};
    ge      = rem_sh >= {1'b0, d_r};
    rem_sub = rem_sh - {1'b0, d_r};
    acc2    = madd(acc_r, acc_r, m_r);
    acc3    = madd(acc2, t_r, m_r);

    n_nxt    = n_r;
    d_nxt    = d_r;
    t_nxt    = t_r;
    m_nxt    = m_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      n_nxt   = {n_r[W-2:0], 1'b0};
      rem_nxt = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      acc_nxt = ge ? acc3 : acc2;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      n_nxt    = n_in;
      d_nxt    = d_in;
      t_nxt    = t_in;
      m_nxt    = m_in;
      rem_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    t_r   <= t_nxt;
    m_r   <= m_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;
  assign prod      = acc_r;

  `ASSERT_IMP(a_done_not_busy, done_r, !busy_r, "serial unit done while busy")
  `ASSERT_IMP(a_start_runs, start && !busy_r && !done_r, ##1 busy_r, "start did not launch")
  `ASSERT_IMP(a_busy_done, busy_r && cnt_r == CW'(W - 1), ##1 done_r, "run did not finish")

endmodule

// ===== src/ec_affine_point_add.sv =====
// affine point addition on a short weierstrass curve over a prime field
// top level: sequencer, config registers and result register
// depends on eca_pkg, eca_serial_unit and assert_macros.svh
//
// usage:
//  - cfg port: write modulus (index 0) and curve_a (index 1) while idle;
//    only the low FIELD_BITS bits are kept
//  - input transaction carries both points, (0,0) is the point at infinity
//  - one result transaction per input: the sum point, (0,0) for infinity
//    (also for a modulus below 2 or a denominator with no inverse)
// timing:
//  - reductions, multiplies and euclid quotients run on one bit-serial
//    unit; additions and subtractions are done in the sequencer itself
//  - general add: 5 reductions, up to about 1.45*FIELD_BITS euclid steps
//    for the inverse, then 3 multiplies; doubling adds one more multiply;
//    a trivial case (infinity operand) skips the unit, and in the worst
//    case the inverse loop takes the largest share of the time
//  - one transaction at a time; in_tready is high only while idle
// reset: synchronous active-low, modulus back to 3 and curve_a to 0
// stall: a held result stays in the output register; the next transaction
//   is accepted and computed meanwhile and waits only to be written out
`include "assert_macros.svh"

module ec_affine_point_add #(
  parameter int FIELD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // first_x, first_y, second_x, second_y
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // sum_x, sum_y
);

  localparam int W  = FIELD_BITS;
  localparam int DB = eca_pkg::DATA_BITS;

  eca_pkg::state_t    state_r, state_nxt;
  eca_pkg::sdu_stat_t su_stat;

  logic [W-1:0] modulus_r, curve_a_r;
  logic [W-1:0] x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt, a_r, a_nxt;
  logic [W-1:0] num_r, num_nxt, tmp_r, tmp_nxt, lam_r, lam_nxt;
  logic [W-1:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0] x3_r, x3_nxt, res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [2:0]   red_idx_r, red_idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;

  logic [W-1:0] su_n, su_d, su_t, su_rem, su_prod, red_val;
  logic         su_start, op_state;

  function automatic logic [W-1:0] madd(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W-1:0] gap;
    gap  = m - b;
    madd = (a >= gap) ? (a - gap) : (a + b);
  endfunction

  function automatic logic [W-1:0] msub(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    msub = (a >= b) ? (a - b) : (a + (m - b));
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(3);
      curve_a_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        eca_pkg::CFG_MODULUS: modulus_r <= cfg_wdata[W-1:0];
        eca_pkg::CFG_CURVE_A: curve_a_r <= cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate or curve_a being reduced
  always_comb begin
    case (red_idx_r)
      3'd0:    red_val = x1_r;
      3'd1:    red_val = y1_r;
      3'd2:    red_val = x2_r;
      3'd3:    red_val = y2_r;
      default: red_val = a_r;
    endcase
  end

  // operands of the serial unit; a multiply is a divide by one
  always_comb begin
    op_state = 1'b1;
    su_n     = '0;
    su_d     = W'(1);
    su_t     = '0;
    unique case (state_r)
      eca_pkg::ST_RED: begin
        su_n = red_val;
        su_d = modulus_r;
      end
      eca_pkg::ST_DSQ: begin
        su_n = x1_r;
        su_t = x1_r;
      end
      eca_pkg::ST_INV: begin
        su_n = r0_r;
        su_d = r1_r;
        su_t = t1_r;
      end
      eca_pkg::ST_LAM: begin
        su_n = t0_r;
        su_t = num_r;
      end
      eca_pkg::ST_SQR: begin
        su_n = lam_r;
        su_t = lam_r;
      end
      eca_pkg::ST_YMUL: begin
        su_n = tmp_r;
        su_t = lam_r;
      end
      default: op_state = 1'b0;
    endcase
  end

  assign su_start = op_state && !su_stat.busy && !su_stat.done &&
                    !(state_r == eca_pkg::ST_INV && r1_r == '0);

  eca_serial_unit #(.W(W)) u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .start (su_start),
    .n_in  (su_n),
    .d_in  (su_d),
    .t_in  (su_t),
    .m_in  (modulus_r),
    .stat  (su_stat),
    .rem   (su_rem),
    .prod  (su_prod)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    a_nxt         = a_r;
    num_nxt       = num_r;
    tmp_nxt       = tmp_r;
    lam_nxt       = lam_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    x3_nxt        = x3_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    red_idx_nxt   = red_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    in_tready     = (state_r == eca_pkg::ST_IDLE);

    unique case (state_r)
      eca_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x1_nxt    = in_tdata[W-1:0];
          y1_nxt    = in_tdata[DB+W-1:DB];
          x2_nxt    = in_tdata[2*DB+W-1:2*DB];
          y2_nxt    = in_tdata[3*DB+W-1:3*DB];
          a_nxt     = curve_a_r;
          state_nxt = eca_pkg::ST_CHECK;
        end
      end
      eca_pkg::ST_CHECK: begin
        red_idx_nxt = '0;
        res_x_nxt   = '0;
        res_y_nxt   = '0;
        state_nxt   = eca_pkg::ST_DONE;
        if (modulus_r < W'(2)) begin
          // degenerate field, result stays at infinity
        end else if (x1_r == '0 && y1_r == '0) begin
          res_x_nxt = x2_r;
          res_y_nxt = y2_r;
        end else if (x2_r == '0 && y2_r == '0) begin
          res_x_nxt = x1_r;
          res_y_nxt = y1_r;
        end else begin
          state_nxt = eca_pkg::ST_RED;
        end
      end
      eca_pkg::ST_RED: begin
        if (su_stat.done) begin
          case (red_idx_r)
            3'd0:    x1_nxt = su_rem;
            3'd1:    y1_nxt = su_rem;
            3'd2:    x2_nxt = su_rem;
            3'd3:    y2_nxt = su_rem;
            default: a_nxt  = su_rem;
          endcase
          red_idx_nxt = red_idx_r + 3'd1;
          if (red_idx_r == 3'd4) begin
            state_nxt = eca_pkg::ST_CMP;
          end
        end
      end
      eca_pkg::ST_CMP: begin
        r0_nxt = modulus_r;
        t0_nxt = '0;
        t1_nxt = W'(1);
        if (x1_r == x2_r && madd(y1_r, y2_r, modulus_r) == '0) begin
          state_nxt = eca_pkg::ST_DONE;
        end else if (x1_r == x2_r && y1_r == y2_r) begin
          state_nxt = eca_pkg::ST_DSQ;
        end else begin
          num_nxt   = msub(y2_r, y1_r, modulus_r);
          r1_nxt    = msub(x2_r, x1_r, modulus_r);
          state_nxt = eca_pkg::ST_INV;
        end
      end
      eca_pkg::ST_DSQ: begin
        if (su_stat.done) begin
          num_nxt   = su_prod;
          state_nxt = eca_pkg::ST_D2;
        end
      end
      eca_pkg::ST_D2: begin
        tmp_nxt   = madd(num_r, num_r, modulus_r);
        state_nxt = eca_pkg::ST_D3;
      end
      eca_pkg::ST_D3: begin
        num_nxt   = madd(tmp_r, num_r, modulus_r);
        state_nxt = eca_pkg::ST_DA;
      end
      eca_pkg::ST_DA: begin
        num_nxt   = madd(num_r, a_r, modulus_r);
        r1_nxt    = madd(y1_r, y1_r, modulus_r);
        state_nxt = eca_pkg::ST_INV;
      end
      eca_pkg::ST_INV: begin
        // euclid: one quotient per run, cofactor updated alongside
        if (su_stat.done) begin
          r0_nxt = r1_r;
          r1_nxt = su_rem;
          t0_nxt = t1_r;
          t1_nxt = msub(t0_r, su_prod, modulus_r);
        end else if (!su_stat.busy && r1_r == '0) begin
          state_nxt = (r0_r == W'(1)) ? eca_pkg::ST_LAM : eca_pkg::ST_DONE;
        end
      end
      eca_pkg::ST_LAM: begin
        if (su_stat.done) begin
          lam_nxt   = su_prod;
          state_nxt = eca_pkg::ST_SQR;
        end
      end
      eca_pkg::ST_SQR: begin
        if (su_stat.done) begin
          tmp_nxt   = su_prod;
          state_nxt = eca_pkg::ST_X3A;
        end
      end
      eca_pkg::ST_X3A: begin
        tmp_nxt   = msub(tmp_r, x1_r, modulus_r);
        state_nxt = eca_pkg::ST_X3B;
      end
      eca_pkg::ST_X3B: begin
        x3_nxt    = msub(tmp_r, x2_r, modulus_r);
        state_nxt = eca_pkg::ST_XD;
      end
      eca_pkg::ST_XD: begin
        tmp_nxt   = msub(x1_r, x3_r, modulus_r);
        state_nxt = eca_pkg::ST_YMUL;
      end
      eca_pkg::ST_YMUL: begin
        if (su_stat.done) begin
          tmp_nxt   = su_prod;
          state_nxt = eca_pkg::ST_Y3;
        end
      end
      eca_pkg::ST_Y3: begin
        res_x_nxt = x3_r;
        res_y_nxt = msub(tmp_r, y1_r, modulus_r);
        state_nxt = eca_pkg::ST_DONE;
      end
      eca_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          sx_nxt        = res_x_r;
          sy_nxt        = res_y_r;
          state_nxt     = eca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      red_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      red_idx_r   <= red_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    x2_r    <= x2_nxt;
    y2_r    <= y2_nxt;
    a_r     <= a_nxt;
    num_r   <= num_nxt;
    tmp_r   <= tmp_nxt;
    lam_r   <= lam_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    x3_r    <= x3_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {DB'(sy_r), DB'(sx_r)};

  `ASSERT_IMP(a_accept_check, in_tvalid && in_tready, ##1 state_r == eca_pkg::ST_CHECK,
              "accepted transaction did not reach check")
  `ASSERT_IMP(a_done_in_op, su_stat.done, op_state, "serial unit result outside an op state")
  `ASSERT_CLK(a_red_idx, red_idx_r <= 3'd5, "reduction index out of range")

endmodule

// ===== tb/sv/tb_ec_affine_point_add.sv =====
// self-checking testbench of the affine point adder ec_affine_point_add
// drives point pairs on the input stream and checks sums against an in-bench field model
// depends on eca_pkg and the rtl of ec_affine_point_add
module tb_ec_affine_point_add;
  timeunit 1ns;
  timeprecision 1ps;

  // worst case per transaction is about 101 serial runs
  localparam int OP_CYCLES   = 7000;
  localparam int ITEMS       = 850;
  localparam int CYCLE_LIMIT = 5 * (ITEMS + 50) * OP_CYCLES;

  // eight primes, mostly small ones so that special cases turn up often
  localparam logic [63:0] PRIMES [8] = '{
    64'd3, 64'd5, 64'd7, 64'd17, 64'd97, 64'd65521,
    64'd4294967291, 64'hFFFF_FFFF_FFFF_FFC5
  };

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
  } point_t;

  typedef struct {
    point_t p1;
    point_t p2;
    bit     has_sum;   // expected sum typed in
    point_t sum;
  } vec_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic         cfg_addr;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;   // first_x, first_y, second_x, second_y
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // sum_x, sum_y

  ec_affine_point_add u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor copy of the configuration registers
  logic [63:0] field_p;
  logic [63:0] coef_a;

  point_t sum_queue[$];
  int     errors;
  longint cycle;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_off;

  task automatic report(input string what, input point_t got, input point_t want);
    $display("mismatch %s: got (%h,%h) expected (%h,%h)", what, got.x, got.y, want.x, want.y);
    errors++;
  endtask

  // ---------------- field arithmetic ----------------

  function automatic logic [63:0] f_add(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] gap;
    gap = m - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic logic [63:0] f_sub(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [63:0] f_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  // extended euclid; ok is cleared when v has no inverse modulo m
  function automatic logic [63:0] f_inv(logic [63:0] v, logic [63:0] m, output bit ok);
    logic [63:0] r0, r1, t0, t1, q, nr, nt;
    r0 = m;
    r1 = v;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = f_sub(t0, f_mul(q % m, t1, m), m);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    ok = (r0 == 1);
    return t0;
  endfunction

  // sum of two affine points under the current field settings
  function automatic point_t point_sum(point_t p, point_t q);
    logic [63:0] m, x1, y1, x2, y2, a, num, den, inv, lam, x3, y3;
    bit ok;
    point_t r;
    m = field_p;
    r = '0;
    if (m < 2) return r;
    if (p.x == 0 && p.y == 0) return q;
    if (q.x == 0 && q.y == 0) return p;
    x1 = p.x % m;
    y1 = p.y % m;
    x2 = q.x % m;
    y2 = q.y % m;
    a  = coef_a % m;
    if (x1 == x2 && f_add(y1, y2, m) == 0) return r;
    if (x1 == x2 && y1 == y2) begin
      num = f_mul(x1, x1, m);
      num = f_add(f_add(num, num, m), num, m);
      num = f_add(num, a, m);
      den = f_add(y1, y1, m);
    end else begin
      num = f_sub(y2, y1, m);
      den = f_sub(x2, x1, m);
    end
    inv = f_inv(den, m, ok);
    if (!ok) return r;
    lam = f_mul(num, inv, m);
    x3  = f_sub(f_sub(f_mul(lam, lam, m), x1, m), x2, m);
    y3  = f_sub(f_mul(lam, f_sub(x1, x3, m), m), y1, m);
    r.x = x3;
    r.y = y3;
    return r;
  endfunction

  // ---------------- drivers ----------------

  task automatic write_reg(input logic idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == eca_pkg::CFG_MODULUS) field_p = val;
    else coef_a = val;
  endtask

  // one input transaction; the expectation is queued when it is accepted
  // tvalid stays up into the next call so back-to-back transactions have no gap
  task automatic send_pair(input point_t p, input point_t q, input bit has_sum,
                           input point_t want);
    point_t pred;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pred = point_sum(p, q);
    if (has_sum && pred != want) report("table vs predictor", pred, want);
    in_tvalid <= 1'b1;
    in_tdata  <= {q.y, q.x, p.y, p.x};
    do @(posedge clk); while (!in_tready);
    sum_queue.push_back(has_sum ? want : pred);
  endtask

  // wait for every expected sum, then let the block settle
  task automatic drain;
    in_tvalid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // ---------------- receiver and checker ----------------

  always @(posedge clk) begin
    point_t got;
    // halves swapped since point_t holds x in its upper bits
    got = point_t'({out_tdata[63:0], out_tdata[127:64]});
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sum_queue.size() == 0) begin
          report("unexpected transaction", got, '0);
        end else begin
          point_t want;
          want = sum_queue.pop_front();
          if (out_tdata[63:0] != want.x) report("sum_x", got, want);
          else if (out_tdata[127:64] != want.y) report("sum_y", got, want);
        end
      end
      out_tready <= !hold_off &&
                    !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic point_t pt(logic [63:0] x, logic [63:0] y);
    point_t r;
    r.x = x;
    r.y = y;
    return r;
  endfunction

  function automatic logic [63:0] rand64;
    return {$urandom(), $urandom()};
  endfunction

  // a random field element, sometimes raw 64-bit noise
  function automatic logic [63:0] rand_coord(logic [63:0] m);
    case ($urandom_range(9, 0))
      0: return rand64();
      1: return 0;
      2: return m - 1;
      default: return rand64() % m;
    endcase
  endfunction

  // random pair with a bias toward doubling, inverses and infinity
  task automatic random_pair(input logic [63:0] m);
    point_t p, q;
    p = pt(rand_coord(m), rand_coord(m));
    q = pt(rand_coord(m), rand_coord(m));
    case ($urandom_range(9, 0))
      0: q = p;                                    // doubling
      1: q = pt(p.x, (m - p.y % m) % m);           // inverse points
      2: p = pt(0, 0);                             // infinity first
      3: q = pt(0, 0);                             // infinity second
      4: q.x = p.x;                                // equal x, other y
      default: ;
    endcase
    send_pair(p, q, 1'b0, '0);
  endtask

  // ---------------- stimulus ----------------

  vec_t   dir_tab[$];
  int     n;
  logic [63:0] m;
  logic [63:0] all1 = '1;

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = eca_pkg::CFG_MODULUS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    errors    = 0;
    cycle     = 0;
    hold_off  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    field_p = 64'd3;
    coef_a  = 64'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: reset settings p=3, a=0 first
    dir_tab.push_back('{pt(0, 0), pt(0, 0), 1, pt(0, 0)});
    dir_tab.push_back('{pt(0, 0), pt(all1, all1), 1, pt(all1, all1)});
    dir_tab.push_back('{pt(all1, 5), pt(0, 0), 1, pt(all1, 5)});
    dir_tab.push_back('{pt(1, 1), pt(1, 2), 1, pt(0, 0)});    // y1+y2 = 0
    dir_tab.push_back('{pt(1, 1), pt(2, 1), 0, '0});
    dir_tab.push_back('{pt(1, 1), pt(1, 1), 0, '0});          // doubling
    dir_tab.push_back('{pt(2, 0), pt(2, 0), 1, pt(0, 0)});    // 2y = 0, inverse pair
    dir_tab.push_back('{pt(4, 1), pt(1, 1), 0, '0});          // unreduced coordinates
    foreach (dir_tab[i]) send_pair(dir_tab[i].p1, dir_tab[i].p2, dir_tab[i].has_sum,
                                   dir_tab[i].sum);
    drain();

    // small modulus gives (0,0) even with an infinity operand
    write_reg(eca_pkg::CFG_MODULUS, 64'd1);
    send_pair(pt(3, 4), pt(5, 6), 1, pt(0, 0));
    send_pair(pt(0, 0), pt(5, 6), 1, pt(0, 0));
    drain();
    write_reg(eca_pkg::CFG_MODULUS, 64'd0);
    send_pair(pt(all1, all1), pt(all1, all1), 1, pt(0, 0));
    drain();

    // composite modulus: some denominators have no inverse
    write_reg(eca_pkg::CFG_MODULUS, 64'd15);
    write_reg(eca_pkg::CFG_CURVE_A, 64'd7);
    send_pair(pt(1, 2), pt(4, 5), 0, '0);
    send_pair(pt(2, 3), pt(2, 3), 0, '0);
    send_pair(pt(1, 2), pt(2, 9), 0, '0);
    drain();

    // largest prime below 2^64, curve_a at its top value
    write_reg(eca_pkg::CFG_MODULUS, PRIMES[7]);
    write_reg(eca_pkg::CFG_CURVE_A, all1);
    send_pair(pt(PRIMES[7] - 1, PRIMES[7] - 1), pt(1, 2), 0, '0);
    send_pair(pt(PRIMES[7] - 1, 3), pt(PRIMES[7] - 1, 3), 0, '0);
    send_pair(pt(all1, all1), pt(all1, 1), 0, '0);
    drain();

    // random part in idling phases, a new setting per phase
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      m = (ph == 7) ? PRIMES[7] : PRIMES[$urandom_range(6, 0)];
      write_reg(eca_pkg::CFG_MODULUS, ($urandom_range(9, 0) == 0) ? rand64() | 64'd3 : m);
      write_reg(eca_pkg::CFG_CURVE_A, ($urandom_range(3, 0) == 0) ? rand64() : rand64() % m);
      m = (field_p < 2) ? 64'd3 : field_p;

      // receiver holds off while the sender keeps offering
      if (ph == 2) fork
        begin
          hold_off = 1'b1;
          repeat (30000) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none

      for (int k = 0; k < ITEMS / 8; k++) begin
        random_pair(m);
        n++;
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (OP_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/eca_pkg.sv
src/eca_serial_unit.sv
src/ec_affine_point_add.sv
tb/sv/tb_ec_affine_point_add.sv
